### rtl/sif_pkg.sv
// Shared types and constants for the safety interlock block.
// No dependencies; imported by every module under rtl.
package sif_pkg;

	localparam int unsigned CfgWidth       = 16;
	localparam int unsigned CfgAddrWidth   = 3;
	localparam int unsigned StrobePeriodMs = 10000;

	// Mode codes
	localparam logic [1:0] MODE_SAFE_OFF = 2'd0;
	localparam logic [1:0] MODE_ARMING   = 2'd1;
	localparam logic [1:0] MODE_ACTIVE   = 2'd2;
	localparam logic [1:0] MODE_FAULT    = 2'd3;

	// Register indexes
	localparam logic [CfgAddrWidth-1:0] REG_BOOT_LOCKOUT  = 3'd0;
	localparam logic [CfgAddrWidth-1:0] REG_RC_FRESH      = 3'd1;
	localparam logic [CfgAddrWidth-1:0] REG_RC_LOW        = 3'd2;
	localparam logic [CfgAddrWidth-1:0] REG_RC_HIGH       = 3'd3;
	localparam logic [CfgAddrWidth-1:0] REG_RC_CONFIRM    = 3'd4;
	localparam logic [CfgAddrWidth-1:0] REG_BATTERY_MIN   = 3'd5;
	localparam logic [CfgAddrWidth-1:0] REG_ARM_CONFIRM   = 3'd6;
	localparam logic [CfgAddrWidth-1:0] REG_FAULT_LOCKOUT = 3'd7;

	localparam logic [7:0] RC_COUNT_MAX = 8'd255;

	typedef struct packed {
		logic [15:0] boot_hold_ms;
		logic [15:0] rc_max_age_ms;
		logic [15:0] rc_low_threshold;
		logic [15:0] rc_high_threshold;
		logic [7:0]  rc_confirm_count;
		logic [15:0] battery_min_mv;
		logic [15:0] arm_hold_ms;
		logic [15:0] fault_hold_ms;
	} sif_cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        link_initialised;
		logic        heartbeat_fresh;
		logic        rc_frames_seen;
		logic [31:0] last_rc_time_ms;
		logic        vehicle_armed;
		logic [15:0] rc_channel_value;
		logic [15:0] battery_mv;
		logic        readback_ok;
		logic        strobe_pass;
	} sif_item_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] cnt_next;
	} sif_gate_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       strobed;
	} sif_res_t;

endpackage

### rtl/sif_cfg.sv
// Configuration register file for the safety interlock.
// Depends on sif_pkg.
module sif_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sif_pkg::CfgAddrWidth-1:0] cfg_addr,
	input  logic [sif_pkg::CfgWidth-1:0]     cfg_wdata,
	output sif_pkg::sif_cfg_t                 cfg
);
	import sif_pkg::*;

	sif_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.boot_hold_ms      <= 16'd3000;
			cfg_q.rc_max_age_ms     <= 16'd500;
			cfg_q.rc_low_threshold  <= 16'd1300;
			cfg_q.rc_high_threshold <= 16'd1700;
			cfg_q.rc_confirm_count  <= 8'd5;
			cfg_q.battery_min_mv    <= 16'd14000;
			cfg_q.arm_hold_ms       <= 16'd500;
			cfg_q.fault_hold_ms     <= 16'd2000;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BOOT_LOCKOUT:  cfg_q.boot_hold_ms      <= cfg_wdata;
				REG_RC_FRESH:      cfg_q.rc_max_age_ms     <= cfg_wdata;
				REG_RC_LOW:        cfg_q.rc_low_threshold  <= cfg_wdata;
				REG_RC_HIGH:       cfg_q.rc_high_threshold <= cfg_wdata;
				REG_RC_CONFIRM:    cfg_q.rc_confirm_count  <= cfg_wdata[7:0];
				REG_BATTERY_MIN:   cfg_q.battery_min_mv    <= cfg_wdata;
				REG_ARM_CONFIRM:   cfg_q.arm_hold_ms       <= cfg_wdata;
				REG_FAULT_LOCKOUT: cfg_q.fault_hold_ms     <= cfg_wdata;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/sif_gates.sv
// Gating condition check and high-run counter update for one word.
// Depends on sif_pkg; purely combinational.
module sif_gates (
	input  sif_pkg::sif_item_t item,
	input  sif_pkg::sif_cfg_t  cfg,
	input  logic [1:0]         mode,
	input  logic [31:0]        start_time,
	input  logic [7:0]         cnt,
	output sif_pkg::sif_gate_t gate
);
	import sif_pkg::*;

	logic [31:0] since_start;
	logic [31:0] rc_age;
	logic        pre_ok;
	logic        rc_high;
	logic [7:0]  cnt_run;
	logic        chan_ok;
	logic        batt_ok;

	always_comb begin
		since_start = item.now_ms - start_time;
		rc_age      = item.now_ms - item.last_rc_time_ms;
		pre_ok = (since_start >= {16'd0, cfg.boot_hold_ms}) &&
			item.link_initialised && item.heartbeat_fresh &&
			(!item.rc_frames_seen || (rc_age <= {16'd0, cfg.rc_max_age_ms})) &&
			item.vehicle_armed;
		rc_high = item.rc_channel_value >= cfg.rc_high_threshold;
		batt_ok = item.battery_mv >= cfg.battery_min_mv;

		// channel check runs only once the earlier checks pass
		cnt_run = cnt;
		chan_ok = 1'b0;
		if (mode == MODE_ACTIVE) begin
			if (item.rc_channel_value < cfg.rc_low_threshold) begin
				cnt_run = '0;
			end else begin
				if (cnt < cfg.rc_confirm_count) cnt_run = cfg.rc_confirm_count;
				chan_ok = 1'b1;
			end
		end else begin
			if (rc_high) begin
				cnt_run = (cnt == RC_COUNT_MAX) ? cnt : cnt + 8'd1;
			end else begin
				cnt_run = '0;
			end
			chan_ok = cnt_run >= cfg.rc_confirm_count;
		end

		gate.cnt_next = pre_ok ? cnt_run : cnt;
		gate.ok       = pre_ok && chan_ok && batt_ok;
	end

endmodule

### rtl/sif_fsm.sv
// Interlock mode sequencer: state registers and next-state logic.
// Depends on sif_pkg and sif_gates.
module sif_fsm #(
	parameter int unsigned STROBE_PERIOD_MS = sif_pkg::StrobePeriodMs
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  sif_pkg::sif_item_t item,
	input  sif_pkg::sif_cfg_t  cfg,
	output sif_pkg::sif_res_t  res,
	output logic [1:0]         mode_cur
);
	import sif_pkg::*;

	logic [1:0]  mode_q;
	logic [31:0] entry_q;
	logic [31:0] start_q;
	logic        started_q;
	logic [7:0]  cnt_q;
	logic [31:0] strobe_q;

	logic [31:0] now;
	logic [31:0] start_eff;
	logic [31:0] entry_eff;
	logic [31:0] strobe_eff;
	sif_gate_t   gate;

	logic [1:0]  mode_d;
	logic        go;
	logic [7:0]  cnt_d;
	logic [31:0] strobe_d;
	logic        strobed;

	assign now        = item.now_ms;
	assign start_eff  = started_q ? start_q : now;
	assign entry_eff  = started_q ? entry_q : now;
	assign strobe_eff = started_q ? strobe_q : now;

	sif_gates u_gates (
		.item       (item),
		.cfg        (cfg),
		.mode       (mode_q),
		.start_time (start_eff),
		.cnt        (cnt_q),
		.gate       (gate)
	);

	always_comb begin
		mode_d   = mode_q;
		go       = 1'b0;
		cnt_d    = cnt_q;
		strobe_d = strobe_eff;
		strobed  = 1'b0;
		if (!item.readback_ok) begin
			mode_d = MODE_FAULT;
			go     = 1'b1;
		end else begin
			cnt_d = gate.cnt_next;
			unique case (mode_q)
				MODE_SAFE_OFF: begin
					if (gate.ok) begin
						mode_d = MODE_ARMING;
						go     = 1'b1;
					end
				end
				MODE_ARMING: begin
					if (!gate.ok) begin
						mode_d = MODE_SAFE_OFF;
						go     = 1'b1;
					end else if ((now - entry_eff) >= {16'd0, cfg.arm_hold_ms}) begin
						strobe_d = now;
						mode_d   = MODE_ACTIVE;
						go       = 1'b1;
					end
				end
				MODE_ACTIVE: begin
					if (!gate.ok) begin
						mode_d = item.heartbeat_fresh ? MODE_SAFE_OFF : MODE_FAULT;
						go     = 1'b1;
					end else if ((now - strobe_eff) >= 32'(STROBE_PERIOD_MS)) begin
						strobed  = 1'b1;
						strobe_d = now;
						if (!item.strobe_pass) begin
							mode_d = MODE_FAULT;
							go     = 1'b1;
						end
					end
				end
				MODE_FAULT: begin
					if ((now - entry_eff) >= {16'd0, cfg.fault_hold_ms}) begin
						cnt_d  = '0;
						mode_d = MODE_SAFE_OFF;
						go     = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_SAFE_OFF;
			started_q <= 1'b0;
			cnt_q     <= '0;
		end else if (step) begin
			mode_q    <= mode_d;
			started_q <= 1'b1;
			cnt_q     <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			start_q  <= start_eff;
			entry_q  <= go ? now : entry_eff;
			strobe_q <= strobe_d;
		end
	end

	assign res.mode    = mode_d;
	assign res.strobed = strobed;
	assign mode_cur    = mode_q;

endmodule

### rtl/safety_interlock_fsm_top.sv
// Safety interlock top: an accepted word passes the input register, one pass of
// mode logic and the result register; one word per cycle while out_ready does
// not stall the result. Mode state updates on the result-load edge, so a word
// may follow its predecessor directly. Reset (arst_n low) puts the mode in
// safe-off, clears the high-run count, loads register defaults, and empties both stages.
// Depends on sif_pkg, sif_cfg, sif_gates and sif_fsm.
module safety_interlock_fsm_top #(
	parameter int unsigned STROBE_PERIOD_MS = sif_pkg::StrobePeriodMs
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [sif_pkg::CfgAddrWidth-1:0] cfg_addr,
	input  logic [sif_pkg::CfgWidth-1:0]     cfg_wdata,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [31:0]                       now_ms,
	input  logic                              link_initialised,
	input  logic                              heartbeat_fresh,
	input  logic                              rc_frames_seen,
	input  logic [31:0]                       last_rc_time_ms,
	input  logic                              vehicle_armed,
	input  logic [15:0]                       rc_channel_value,
	input  logic [15:0]                       battery_mv,
	input  logic                              readback_ok,
	input  logic                              strobe_pass,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        switch_state,
	output logic                              relay_on,
	output logic                              switch_on,
	output logic                              strobe_run
);
	import sif_pkg::*;

	sif_cfg_t   cfg;
	sif_item_t  item_s1;
	logic       valid_s1;
	logic       step;
	sif_res_t   res;
	logic [1:0] mode_cur;

	logic       out_valid_q;
	logic [1:0] state_q;
	logic       strobe_q;

	sif_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Advance stage 1 into the result register whenever that register is
	// free or is being drained this cycle. The mode state updates on the
	// same edge, so the next word in stage 1 sees the updated state.
	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the incoming word; payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.now_ms           <= now_ms;
			item_s1.link_initialised <= link_initialised;
			item_s1.heartbeat_fresh  <= heartbeat_fresh;
			item_s1.rc_frames_seen   <= rc_frames_seen;
			item_s1.last_rc_time_ms  <= last_rc_time_ms;
			item_s1.vehicle_armed    <= vehicle_armed;
			item_s1.rc_channel_value <= rc_channel_value;
			item_s1.battery_mv       <= battery_mv;
			item_s1.readback_ok      <= readback_ok;
			item_s1.strobe_pass      <= strobe_pass;
		end
	end

	sif_fsm #(
		.STROBE_PERIOD_MS (STROBE_PERIOD_MS)
	) u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (item_s1),
		.cfg      (cfg),
		.res      (res),
		.mode_cur (mode_cur)
	);

	// Result register: hold until taken, reload on each step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			state_q  <= res.mode;
			strobe_q <= res.strobed;
		end
	end

	assign out_valid    = out_valid_q;
	assign switch_state = state_q;
	assign relay_on     = (state_q == MODE_ACTIVE);
	assign switch_on    = (state_q == MODE_ACTIVE);
	assign strobe_run   = strobe_q;

	// A strobe only runs from active, so the reported mode is active or fault.
	a_strobe_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && strobe_run |-> (switch_state == MODE_ACTIVE) ||
			(switch_state == MODE_FAULT))
		else $error("strobe reported outside active or fault");

	// The mode register moves only when a word is processed.
	a_mode_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(mode_cur))
		else $error("mode changed without a word");

	// The reported mode is the one the sequencer holds after that word.
	a_mode_match: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (switch_state == mode_cur))
		else $error("result mode differs from stored mode");

endmodule
